>>> hdl/dfr_pkg.sv
// dfr_pkg: shared types and constants for the packet deframer
// no dependencies; imported by dfr_parser, dfr_out_stage and the top level
`timescale 1ns / 1ps

package dfr_pkg;

  localparam logic [7:0] SYNC_0_BYTE      = 8'h55;
  localparam logic [7:0] SYNC_1_BYTE      = 8'h4E;
  localparam logic [7:0] SYNC_2_BYTE      = 8'h45;
  localparam logic [7:0] SYNC_3_BYTE      = 8'h52;
  localparam logic [7:0] ZERO_BYTE        = 8'h00;
  localparam logic [7:0] COLON_BYTE       = 8'h3A;
  localparam logic [7:0] CODE_ALIVE       = 8'hF0;
  localparam logic [7:0] CODE_MOTOR_SET   = 8'hD0;
  localparam logic [7:0] CODE_MOTOR_ONOFF = 8'hD2;

  // fixed header bytes folded into the checksum seed (length byte added at run time)
  localparam logic [7:0] HEADER_XOR =
    SYNC_0_BYTE ^ SYNC_1_BYTE ^ SYNC_2_BYTE ^ SYNC_3_BYTE ^ ZERO_BYTE ^ COLON_BYTE;

  localparam int STAGE_DEPTH = 8;
  localparam logic [3:0] POS_LAST = 4'd9;

  typedef enum logic [2:0] {
    PH_SYNC0   = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_SYNC2   = 3'd2,
    PH_SYNC3   = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_ZERO    = 3'd5,
    PH_COLON   = 3'd6,
    PH_PAYLOAD = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ALIVE       = 2'd0,
    KIND_MOTOR_SET   = 2'd1,
    KIND_MOTOR_ONOFF = 2'd2,
    KIND_OTHER       = 2'd3
  } kind_t;

  typedef struct packed {
    logic        frame_ok;
    logic [7:0]  command_code;
    kind_t       command_kind;
    logic [31:0] motor_one_word;
    logic [31:0] motor_two_word;
  } result_t;

  function automatic kind_t kind_of(input logic [7:0] code);
    kind_t k;
    priority if (code == CODE_ALIVE)       k = KIND_ALIVE;
    else if (code == CODE_MOTOR_SET)       k = KIND_MOTOR_SET;
    else if (code == CODE_MOTOR_ONOFF)     k = KIND_MOTOR_ONOFF;
    else                                   k = KIND_OTHER;
    return k;
  endfunction

  function automatic phase_t restart_on(input logic [7:0] b);
    return (b == SYNC_0_BYTE) ? PH_SYNC1 : PH_SYNC0;
  endfunction

endpackage

>>> hdl/dfr_parser.sv
// dfr_parser: header hunt, payload count, running xor and payload staging
// depends on dfr_pkg
`timescale 1ns / 1ps

module dfr_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             has_result,
  output dfr_pkg::result_t result
);
  import dfr_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [3:0]  position, position_next;
  logic [7:0]  command_held, command_held_next;
  logic [7:0]  staged [STAGE_DEPTH];
  logic [7:0]  staged_next [STAGE_DEPTH];
  logic [2:0]  pos_dec;

  assign pos_dec    = position[2:0] - 3'd1;
  assign has_result = (phase == PH_PAYLOAD) && (bytes_left == 8'd1);

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    running_xor_next  = running_xor;
    position_next     = position;
    command_held_next = command_held;
    for (int i = 0; i < STAGE_DEPTH; i++) staged_next[i] = staged[i];

    unique case (phase)
      PH_SYNC0:  phase_next = restart_on(rx_byte);
      PH_SYNC1:  phase_next = (rx_byte == SYNC_1_BYTE) ? PH_SYNC2 : restart_on(rx_byte);
      PH_SYNC2:  phase_next = (rx_byte == SYNC_2_BYTE) ? PH_SYNC3 : restart_on(rx_byte);
      PH_SYNC3:  phase_next = (rx_byte == SYNC_3_BYTE) ? PH_LENGTH : restart_on(rx_byte);
      PH_LENGTH: begin
        bytes_left_next = rx_byte;
        phase_next      = PH_ZERO;
      end
      PH_ZERO:   phase_next = (rx_byte == ZERO_BYTE) ? PH_COLON : restart_on(rx_byte);
      PH_COLON: begin
        if (rx_byte == COLON_BYTE) begin
          running_xor_next  = HEADER_XOR ^ bytes_left;
          position_next     = 4'd0;
          command_held_next = 8'd0;
          for (int i = 0; i < STAGE_DEPTH; i++) staged_next[i] = 8'd0;
          phase_next        = PH_PAYLOAD;
        end else begin
          phase_next = restart_on(rx_byte);
        end
      end
      PH_PAYLOAD: begin
        if (position == 4'd0) begin
          command_held_next = rx_byte;
        end else if (position <= 4'd8) begin
          staged_next[pos_dec] = rx_byte;
        end
        if (position < POS_LAST) position_next = position + 4'd1;
        if (bytes_left != 8'd1) begin
          running_xor_next = running_xor ^ rx_byte;
          bytes_left_next  = bytes_left - 8'd1;
        end else begin
          bytes_left_next = 8'd0;
          phase_next      = PH_SYNC0;
        end
      end
      default: phase_next = PH_SYNC0;
    endcase
  end

  // result is built from the staging as it stands after this byte
  always_comb begin
    result.frame_ok       = (running_xor == rx_byte);
    result.command_code   = command_held_next;
    result.command_kind   = kind_of(command_held_next);
    result.motor_one_word = {staged_next[3], staged_next[2], staged_next[1], staged_next[0]};
    result.motor_two_word = {staged_next[7], staged_next[6], staged_next[5], staged_next[4]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC0;
      bytes_left  <= 8'd0;
      running_xor <= 8'd0;
      position    <= 4'd0;
    end else if (step) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      running_xor <= running_xor_next;
      position    <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      command_held <= command_held_next;
      for (int i = 0; i < STAGE_DEPTH; i++) staged[i] <= staged_next[i];
    end
  end

`ifndef ASSERT_OFF
  a_frame_end_rehunts: assert property (@(posedge clk) disable iff (rst)
    step && has_result |=> phase == PH_SYNC0 && bytes_left == 8'd0)
    else $error("parser did not return to hunt after frame end");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position <= POS_LAST)
    else $error("payload position ran past its hold value");

  a_seed_on_colon: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_COLON && rx_byte == COLON_BYTE |=>
      position == 4'd0 && running_xor == (HEADER_XOR ^ bytes_left))
    else $error("checksum seed wrong at payload start");
`endif

endmodule

>>> hdl/dfr_out_stage.sv
// dfr_out_stage: result register holding one frame result until taken
// depends on dfr_pkg
`timescale 1ns / 1ps

module dfr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dfr_pkg::result_t result_in,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_ready,
  output dfr_pkg::result_t result_out
);
  import dfr_pkg::*;

  logic    held_valid;
  result_t held;

  assign slot_free  = !held_valid || out_ready;
  assign out_valid  = held_valid;
  assign result_out = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (out_ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= result_in;
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !held_valid || out_ready)
    else $error("result register overwritten while still held");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> held_valid)
    else $error("loaded result not presented");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    held_valid && !out_ready |=> held_valid && $stable(held))
    else $error("stalled result changed");
`endif

endmodule

>>> hdl/xor_checked_packet_deframer_core.sv
// xor_checked_packet_deframer_core: top level of the packet deframer
// depends on dfr_pkg, dfr_parser, dfr_out_stage
`timescale 1ns / 1ps

// Usage
//   input channel: rx_byte with in_valid / in_ready, one serial byte per transaction.
//   output channel: frame_ok, command_code, command_kind, motor_one_word,
//   motor_two_word with out_valid / out_ready, one transaction per complete frame.
//   bytes pass an input register, then the parser updates its state and, on the
//   last payload byte, loads the result register.
//   the last payload byte is taken into the input register; the parser step on it
//   loads the result register, from which out_valid rises.
//   throughput: one byte per cycle (one parser step each) unless stalled as below.
//   a byte that ends no frame never waits on the output side; a frame-ending
//   byte waits in the input register only while a previous result is still held.
//   a stalled receiver holds the result; in_ready drops once the frame-ending
//   byte is blocked and the input register is full.
//   reset (rst, synchronous) puts the parser into sync hunt and empties both
//   registers; no clearing pass is needed.

module xor_checked_packet_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_ok,
  output logic [7:0]  command_code,
  output logic [1:0]  command_kind,
  output logic [31:0] motor_one_word,
  output logic [31:0] motor_two_word
);
  import dfr_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       has_result;
  logic       slot_free;
  logic       advance;
  result_t    result_new;
  result_t    result_out;

  assign advance  = byte_valid && (!has_result || slot_free);
  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_q <= rx_byte;
  end

  dfr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .rx_byte    (byte_q),
    .has_result (has_result),
    .result     (result_new)
  );

  dfr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && has_result),
    .result_in  (result_new),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (result_out)
  );

  assign frame_ok       = result_out.frame_ok;
  assign command_code   = result_out.command_code;
  assign command_kind   = result_out.command_kind;
  assign motor_one_word = result_out.motor_one_word;
  assign motor_two_word = result_out.motor_two_word;

endmodule

>>> test/xor_checked_packet_deframer_core_tb.sv
// xor_checked_packet_deframer_core_tb: self-checking bench for the packet deframer
// depends on dfr_pkg and xor_checked_packet_deframer_core; directed table, then random traffic
`timescale 1ns / 1ps

module xor_checked_packet_deframer_core_tb;
  import dfr_pkg::*;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    result_t    res;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        frame_ok;
  logic [7:0]  command_code;
  logic [1:0]  command_kind;
  logic [31:0] motor_one_word;
  logic [31:0] motor_two_word;

  // shadow parser state
  phase_t      hunt_phase;
  logic [7:0]  left_cnt;
  logic [7:0]  xor_acc;
  logic [3:0]  pay_pos;
  logic [7:0]  cmd_byte;
  logic [7:0]  stage_buf [8];

  result_t     pending_frames [$];
  stim_row_t   directed_rows [$];
  bit          no_idle = 1'b0;
  int          bytes_sent = 0;
  int          frames_predicted = 0;
  int          frames_checked = 0;
  int          mismatch_cnt = 0;

  xor_checked_packet_deframer_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_ok       (frame_ok),
    .command_code   (command_code),
    .command_kind   (command_kind),
    .motor_one_word (motor_one_word),
    .motor_two_word (motor_two_word)
  );

  always #10 clk = ~clk;

  function automatic phase_t sync_or_hunt(input logic [7:0] b);
    return (b == SYNC_0_BYTE) ? PH_SYNC1 : PH_SYNC0;
  endfunction

  function automatic result_t mk_result(input logic ok, input logic [7:0] code,
                                        input kind_t kind, input logic [31:0] w1,
                                        input logic [31:0] w2);
    result_t r;
    r.frame_ok       = ok;
    r.command_code   = code;
    r.command_kind   = kind;
    r.motor_one_word = w1;
    r.motor_two_word = w2;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit typed, input result_t res);
    stim_row_t row;
    row.b     = b;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endfunction

  // advances the shadow parser by one byte; made is set on the frame-ending byte
  task automatic parse_rx_byte(input logic [7:0] b, output bit made, output result_t r);
    kind_t k;
    made = 1'b0;
    r    = NO_RESULT;
    case (hunt_phase)
      PH_SYNC0: hunt_phase = sync_or_hunt(b);
      PH_SYNC1: hunt_phase = (b == SYNC_1_BYTE) ? PH_SYNC2 : sync_or_hunt(b);
      PH_SYNC2: hunt_phase = (b == SYNC_2_BYTE) ? PH_SYNC3 : sync_or_hunt(b);
      PH_SYNC3: hunt_phase = (b == SYNC_3_BYTE) ? PH_LENGTH : sync_or_hunt(b);
      PH_LENGTH: begin
        left_cnt   = b;
        hunt_phase = PH_ZERO;
      end
      PH_ZERO: hunt_phase = (b == ZERO_BYTE) ? PH_COLON : sync_or_hunt(b);
      PH_COLON: begin
        if (b == COLON_BYTE) begin
          xor_acc    = HEADER_XOR ^ left_cnt;
          pay_pos    = 4'd0;
          cmd_byte   = 8'h00;
          stage_buf  = '{default: 8'h00};
          hunt_phase = PH_PAYLOAD;
        end else begin
          hunt_phase = sync_or_hunt(b);
        end
      end
      default: begin
        if (pay_pos == 4'd0) cmd_byte = b;
        else if (pay_pos <= 4'd8) stage_buf[3'(pay_pos - 4'd1)] = b;
        if (pay_pos < POS_LAST) pay_pos = pay_pos + 4'd1;
        if (left_cnt != 8'd1) begin
          xor_acc  = xor_acc ^ b;
          left_cnt = left_cnt - 8'd1;
        end else begin
          left_cnt   = 8'd0;
          hunt_phase = PH_SYNC0;
          case (cmd_byte)
            CODE_ALIVE:       k = KIND_ALIVE;
            CODE_MOTOR_SET:   k = KIND_MOTOR_SET;
            CODE_MOTOR_ONOFF: k = KIND_MOTOR_ONOFF;
            default:          k = KIND_OTHER;
          endcase
          r = mk_result(xor_acc == b, cmd_byte, k,
                        {stage_buf[3], stage_buf[2], stage_buf[1], stage_buf[0]},
                        {stage_buf[7], stage_buf[6], stage_buf[5], stage_buf[4]});
          made = 1'b1;
        end
      end
    endcase
  endtask

  // one input transaction, with random idle cycles in front of it unless no_idle is set
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t typed_res);
    bit      made;
    result_t r;
    if (!no_idle) begin
      while ($urandom_range(99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_rx_byte(b, made, r);
    if (made) frames_predicted++;
    if (typed) pending_frames.push_back(typed_res);
    else if (made) pending_frames.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] len);
    send_byte(SYNC_0_BYTE, 1'b0, NO_RESULT);
    send_byte(SYNC_1_BYTE, 1'b0, NO_RESULT);
    send_byte(SYNC_2_BYTE, 1'b0, NO_RESULT);
    send_byte(SYNC_3_BYTE, 1'b0, NO_RESULT);
    send_byte(len, 1'b0, NO_RESULT);
    send_byte(ZERO_BYTE, 1'b0, NO_RESULT);
    send_byte(COLON_BYTE, 1'b0, NO_RESULT);
  endtask

  // frame with random length, command and payload; the checksum byte is sometimes wrong
  task automatic send_frame();
    int          pick;
    int          n;
    logic [7:0]  len;
    logic [7:0]  code;
    logic [7:0]  sum;
    logic [7:0]  pb;
    pick = $urandom_range(99);
    if (pick < 3) len = 8'd0;                       // wraps to 256 payload bytes
    else if (pick < 75) len = 8'($urandom_range(12, 1));
    else len = 8'($urandom_range(40, 13));
    n = (len == 8'd0) ? 256 : int'(len);
    case ($urandom_range(4))
      0: code = CODE_ALIVE;
      1: code = CODE_MOTOR_SET;
      2: code = CODE_MOTOR_ONOFF;
      default: code = 8'($urandom);
    endcase
    send_header(len);
    sum = HEADER_XOR ^ len;
    for (int i = 0; i < n - 1; i++) begin
      pb = (i == 0) ? code : 8'($urandom);
      send_byte(pb, 1'b0, NO_RESULT);
      sum = sum ^ pb;
    end
    pb = ($urandom_range(9) < 7) ? sum : 8'($urandom);
    send_byte(pb, 1'b0, NO_RESULT);
  endtask

  // header cut short by a bad byte, sometimes a fresh sync start
  task automatic send_broken_header();
    int         cut;
    logic [7:0] hdr [7];
    hdr = '{SYNC_0_BYTE, SYNC_1_BYTE, SYNC_2_BYTE, SYNC_3_BYTE,
            8'($urandom_range(12, 1)), ZERO_BYTE, COLON_BYTE};
    cut = $urandom_range(6, 1);
    for (int i = 0; i < cut; i++) send_byte(hdr[i], 1'b0, NO_RESULT);
    send_byte(($urandom_range(2) == 0) ? SYNC_0_BYTE : 8'($urandom), 1'b0, NO_RESULT);
  endtask

  // output side: random back-pressure and in-order compare
  always @(posedge clk) begin
    result_t want;
    out_ready <= no_idle || ($urandom_range(99) >= 37);
    if (!rst && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        $error("result with no frame expected: code %0h", command_code);
        mismatch_cnt++;
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (frame_ok !== want.frame_ok) begin
          $error("frame_ok: expected %0h, got %0h", want.frame_ok, frame_ok);
          mismatch_cnt++;
        end
        if (command_code !== want.command_code) begin
          $error("command_code: expected %0h, got %0h", want.command_code, command_code);
          mismatch_cnt++;
        end
        if (command_kind !== 2'(want.command_kind)) begin
          $error("command_kind: expected %0h, got %0h", want.command_kind, command_kind);
          mismatch_cnt++;
        end
        if (motor_one_word !== want.motor_one_word) begin
          $error("motor_one_word: expected %0h, got %0h", want.motor_one_word,
                 motor_one_word);
          mismatch_cnt++;
        end
        if (motor_two_word !== want.motor_two_word) begin
          $error("motor_two_word: expected %0h, got %0h", want.motor_two_word,
                 motor_two_word);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int sel;
    rst        = 1'b1;
    in_valid   = 1'b0;
    rx_byte    = 8'h00;
    out_ready  = 1'b0;
    hunt_phase = PH_SYNC0;
    left_cnt   = 8'h00;
    xor_acc    = 8'h00;
    pay_pos    = 4'd0;
    cmd_byte   = 8'h00;
    stage_buf  = '{default: 8'h00};

    // non-sync byte while hunting is dropped
    add_row(8'h00, 1'b0, NO_RESULT);
    // repeated sync start, then a one-byte frame whose checksum is also the command
    add_row(SYNC_0_BYTE, 1'b0, NO_RESULT);
    add_row(SYNC_0_BYTE, 1'b0, NO_RESULT);
    add_row(SYNC_1_BYTE, 1'b0, NO_RESULT);
    add_row(SYNC_2_BYTE, 1'b0, NO_RESULT);
    add_row(SYNC_3_BYTE, 1'b0, NO_RESULT);
    add_row(8'h01, 1'b0, NO_RESULT);
    add_row(ZERO_BYTE, 1'b0, NO_RESULT);
    add_row(COLON_BYTE, 1'b0, NO_RESULT);
    add_row(HEADER_XOR ^ 8'h01, 1'b1,
            mk_result(1'b1, HEADER_XOR ^ 8'h01, KIND_OTHER, 32'h0, 32'h0));
    // alive frame with a bad checksum byte of all ones
    add_row(SYNC_0_BYTE, 1'b0, NO_RESULT);
    add_row(SYNC_1_BYTE, 1'b0, NO_RESULT);
    add_row(SYNC_2_BYTE, 1'b0, NO_RESULT);
    add_row(SYNC_3_BYTE, 1'b0, NO_RESULT);
    add_row(8'h02, 1'b0, NO_RESULT);
    add_row(ZERO_BYTE, 1'b0, NO_RESULT);
    add_row(COLON_BYTE, 1'b0, NO_RESULT);
    add_row(CODE_ALIVE, 1'b0, NO_RESULT);
    add_row(8'hFF, 1'b1, mk_result(1'b0, CODE_ALIVE, KIND_ALIVE, 32'h0000_00FF, 32'h0));
    // sync byte where the zero byte belongs restarts the hunt on that byte
    add_row(SYNC_0_BYTE, 1'b0, NO_RESULT);
    add_row(SYNC_1_BYTE, 1'b0, NO_RESULT);
    add_row(SYNC_2_BYTE, 1'b0, NO_RESULT);
    add_row(SYNC_3_BYTE, 1'b0, NO_RESULT);
    add_row(8'h09, 1'b0, NO_RESULT);
    add_row(SYNC_0_BYTE, 1'b0, NO_RESULT);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].res);

    bytes_sent = 0;
    while (bytes_sent < 700) begin
      no_idle = (bytes_sent >= 300 && bytes_sent < 420);
      sel = $urandom_range(99);
      if (sel < 75) send_frame();
      else if (sel < 90) send_broken_header();
      else repeat ($urandom_range(4, 1)) send_byte(8'($urandom), 1'b0, NO_RESULT);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d random bytes after the directed table, checked %0d frames",
             bytes_sent, frames_checked);
    $display("frames mixed good and bad checksums, all command kinds and lengths to 256");
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d frames outstanding", pending_frames.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
